// ----- src/c2ce_pkg.sv -----
// ============================================================================
// c2ce_pkg
// Shared constants and codes for the clamp-to-edge 2D convolution block.
// ============================================================================
package c2ce_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 4;

    localparam int CMD_W   = 2;
    localparam int CIDX_W  = 7;
    localparam int COEF_W  = 16;
    localparam int PIX_W   = 8;
    localparam int RES_W   = 32;
    localparam int IMGW_W  = 11;
    localparam int IMGH_W  = 16;
    localparam int RAD_W   = 3;
    localparam int CFGD_W  = 16;
    localparam int CFGI_W  = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

    localparam logic [CFGI_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFGI_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFGI_W-1:0] REG_RADIUS_X     = 2'd2;
    localparam logic [CFGI_W-1:0] REG_RADIUS_Y     = 2'd3;

    localparam logic [IMGW_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [IMGH_W-1:0] RST_IMAGE_HEIGHT = 16'd480;
    localparam logic [RAD_W-1:0]  RST_RADIUS       = 3'd1;

    localparam int RES_FIFO_DEPTH = 8;

endpackage

// ----- src/c2ce_linebuf.sv -----
// ============================================================================
// c2ce_linebuf
// Banked ring of line memories with one write and one registered read per
// bank, plus forwarding of the pixel written in the read cycle.
// ============================================================================
module c2ce_linebuf #(
    parameter int RING = 10,
    parameter int NB   = 16,
    parameter int AW   = 6
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [$clog2(RING)-1:0]                wr_ring,
    input  logic [$clog2(NB)-1:0]                  wr_bank,
    input  logic [AW-1:0]                          wr_addr,
    input  logic [c2ce_pkg::PIX_W-1:0]             wr_pixel,
    input  logic [NB-1:0][AW-1:0]                  rd_addr,
    output logic [RING-1:0][NB-1:0][c2ce_pkg::PIX_W-1:0] rd_data
);

    localparam int RGW = $clog2(RING);
    localparam int LNB = $clog2(NB);

    logic                         fw_valid_reg;
    logic [RGW-1:0]               fw_ring_reg;
    logic [LNB-1:0]               fw_bank_reg;
    logic [AW-1:0]                fw_addr_reg;
    logic [c2ce_pkg::PIX_W-1:0]   fw_pixel_reg;
    logic [NB-1:0][AW-1:0]        rd_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_valid_reg <= 1'b0;
        end
        else
        begin
            fw_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        fw_ring_reg  <= wr_ring;
        fw_bank_reg  <= wr_bank;
        fw_addr_reg  <= wr_addr;
        fw_pixel_reg <= wr_pixel;
        rd_addr_reg  <= rd_addr;
    end

    for (genvar r = 0; r < RING; r++)
    begin : g_ring
        for (genvar b = 0; b < NB; b++)
        begin : g_bank
            logic [c2ce_pkg::PIX_W-1:0] mem [2**AW];
            logic [c2ce_pkg::PIX_W-1:0] q_reg;

            always_ff @(posedge clk)
            begin
                if (wr_en && (wr_ring == RGW'(r)) && (wr_bank == LNB'(b)))
                begin
                    mem[wr_addr] <= wr_pixel;
                end
                q_reg <= mem[rd_addr[b]];
            end

            assign rd_data[r][b] = (fw_valid_reg && (fw_ring_reg == RGW'(r))
                                    && (fw_bank_reg == LNB'(b))
                                    && (fw_addr_reg == rd_addr_reg[b]))
                                   ? fw_pixel_reg : q_reg;
        end
    end

endmodule

// ----- src/c2ce_mac.sv -----
// ============================================================================
// c2ce_mac
// Coefficient grids, window selection, multipliers and a registered adder
// tree producing one convolved pixel per cycle.
// ============================================================================
module c2ce_mac #(
    parameter int MAX_RADIUS = 4,
    parameter int RING       = 10,
    parameter int NB         = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        ld_en,
    input  logic [c2ce_pkg::CIDX_W-1:0]                 ld_index,
    input  logic signed [c2ce_pkg::COEF_W-1:0]          ld_value,
    input  logic                                        in_valid,
    input  logic                                        in_last,
    input  logic [2*MAX_RADIUS:0][$clog2(RING)-1:0]     in_rr,
    input  logic [2*MAX_RADIUS:0][$clog2(NB)-1:0]       in_bk,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]             in_rx,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]             in_ry,
    input  logic [RING-1:0][NB-1:0][c2ce_pkg::PIX_W-1:0] rd_data,
    output logic                                        res_valid,
    output logic                                        res_last,
    output logic signed [c2ce_pkg::RES_W-1:0]           res_value
);

    localparam int KSIDE = 2 * MAX_RADIUS + 1;
    localparam int PW    = c2ce_pkg::PIX_W + c2ce_pkg::COEF_W + 1;

    logic signed [c2ce_pkg::COEF_W-1:0] grid [MAX_RADIUS+1][KSIDE][KSIDE];

    logic [c2ce_pkg::PIX_W-1:0]         pix_c   [KSIDE][KSIDE];
    logic signed [c2ce_pkg::COEF_W-1:0] coef_c  [KSIDE][KSIDE];
    logic [c2ce_pkg::PIX_W-1:0]         pix_reg [KSIDE][KSIDE];
    logic signed [c2ce_pkg::COEF_W-1:0] coef_reg[KSIDE][KSIDE];
    logic signed [PW-1:0]               prod_reg[KSIDE][KSIDE];
    logic signed [c2ce_pkg::RES_W-1:0]  row_c   [KSIDE];
    logic signed [c2ce_pkg::RES_W-1:0]  row_reg [KSIDE];
    logic                               s2_valid_reg;
    logic                               s2_last_reg;
    logic                               s3_valid_reg;
    logic                               s3_last_reg;
    logic                               s4_valid_reg;
    logic                               s4_last_reg;

    for (genvar g = 0; g <= MAX_RADIUS; g++)
    begin : g_kw
        for (genvar y = 0; y < KSIDE; y++)
        begin : g_y
            for (genvar x = 0; x < KSIDE; x++)
            begin : g_x
                localparam int LI = y * (2 * g + 1) + x;
                always_ff @(posedge clk)
                begin
                    if (ld_en && (x < 2 * g + 1) && (32'(ld_index) == LI))
                    begin
                        grid[g][y][x] <= ld_value;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int y = 0; y < KSIDE; y++)
        begin
            for (int x = 0; x < KSIDE; x++)
            begin
                pix_c[y][x] = rd_data[in_rr[y]][in_bk[x]];
                if ((x <= 2 * int'(in_rx)) && (y <= 2 * int'(in_ry)))
                begin
                    coef_c[y][x] = grid[in_rx][y][x];
                end
                else
                begin
                    coef_c[y][x] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int y = 0; y < KSIDE; y++)
        begin
            row_c[y] = '0;
            for (int x = 0; x < KSIDE; x++)
            begin
                row_c[y] = row_c[y] + c2ce_pkg::RES_W'(prod_reg[y][x]);
            end
        end
    end

    always_comb
    begin
        res_value = '0;
        for (int y = 0; y < KSIDE; y++)
        begin
            res_value = res_value + row_reg[y];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg <= in_last;
        s3_last_reg <= s2_last_reg;
        s4_last_reg <= s3_last_reg;
        pix_reg     <= pix_c;
        coef_reg    <= coef_c;
        for (int y = 0; y < KSIDE; y++)
        begin
            for (int x = 0; x < KSIDE; x++)
            begin
                prod_reg[y][x] <= $signed({1'b0, pix_reg[y][x]}) * coef_reg[y][x];
            end
        end
        row_reg <= row_c;
    end

    assign res_valid = s4_valid_reg;
    assign res_last  = s4_last_reg;

endmodule

// ----- src/conv2d_clamp_edge_top.sv -----
// ============================================================================
// conv2d_clamp_edge_top
// Streaming 2D convolution of a gray image with clamp-to-edge borders.
//
//   Channel  Direction  Handshake             Payload
//   item     in         item_valid/item_stall cmd, coef_index, coef_value, pixel
//   res      out        res_valid/res_stall   result, frame_last
//   config   in         cfg_we                cfg_index, cfg_data
//
// One item is taken every cycle while item_stall is low. A released output
// passes the line memory read, window select, multiply and a two-level
// adder tree before it enters the queue.
// Results wait in an eight-entry queue;
// item_stall rises only when eight results are in flight or waiting.
// Reset restores the register defaults and empties the pipeline.
// ============================================================================
module conv2d_clamp_edge_top #(
    parameter int MAX_WIDTH  = c2ce_pkg::MAX_WIDTH,
    parameter int MAX_RADIUS = c2ce_pkg::MAX_RADIUS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [c2ce_pkg::CMD_W-1:0]          cmd,
    input  logic [c2ce_pkg::CIDX_W-1:0]         coef_index,
    input  logic signed [c2ce_pkg::COEF_W-1:0]  coef_value,
    input  logic [c2ce_pkg::PIX_W-1:0]          pixel,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic signed [c2ce_pkg::RES_W-1:0]   result,
    output logic                                frame_last,
    input  logic                                cfg_we,
    input  logic [c2ce_pkg::CFGI_W-1:0]         cfg_index,
    input  logic [c2ce_pkg::CFGD_W-1:0]         cfg_data
);

    localparam int KSIDE = 2 * MAX_RADIUS + 1;
    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int RGW   = $clog2(RING);
    localparam int LNB   = $clog2(KSIDE);
    localparam int NB    = 2 ** LNB;
    localparam int AW0   = $clog2((MAX_WIDTH + NB - 1) / NB);
    localparam int AW    = (AW0 < 1) ? 1 : AW0;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int HW    = c2ce_pkg::IMGH_W;
    localparam int YW    = HW + 2;
    localparam int CXW   = ((CW > LNB) ? CW : LNB) + 1;
    localparam int XS    = CXW + 1;
    localparam int FQ    = c2ce_pkg::RES_FIFO_DEPTH;
    localparam int FPW   = $clog2(FQ);

    logic [c2ce_pkg::IMGW_W-1:0] image_width_reg;
    logic [c2ce_pkg::IMGH_W-1:0] image_height_reg;
    logic [c2ce_pkg::RAD_W-1:0]  radius_x_reg;
    logic [c2ce_pkg::RAD_W-1:0]  radius_y_reg;

    logic [CW-1:0]  in_col_reg,   in_col_next;
    logic [HW-1:0]  in_row_reg,   in_row_next;
    logic [RGW-1:0] in_ring_reg,  in_ring_next;
    logic [CW-1:0]  xo_reg,       xo_next;
    logic [HW-1:0]  yo_reg,       yo_next;
    logic [RGW-1:0] out_ring_reg, out_ring_next;

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [RW-1:0]  rx_e;
    logic [RW-1:0]  ry_e;
    logic [CW-1:0]  wm1;
    logic [CW-1:0]  rx_lag;

    logic           item_acc;
    logic           pix_take;
    logic           col_last;
    logic [CW-1:0]  pc;
    logic [HW-1:0]  pr;
    logic [RGW-1:0] pring;
    logic [CW:0]    s_sum;
    logic           s_wrap;
    logic [YW-1:0]  tr;
    logic [CW:0]    tc;
    logic           ready;
    logic           release_o;
    logic           last_o;

    logic [KSIDE-1:0][RGW-1:0] rr_c;
    logic [KSIDE-1:0][LNB-1:0] bk_c;
    logic [NB-1:0][AW-1:0]     raddr_c;
    logic [CXW-1:0]            wcol_x;

    logic                      s1_valid_reg;
    logic                      s1_last_reg;
    logic [KSIDE-1:0][RGW-1:0] s1_rr_reg;
    logic [KSIDE-1:0][LNB-1:0] s1_bk_reg;
    logic [RW-1:0]             s1_rx_reg;
    logic [RW-1:0]             s1_ry_reg;

    logic [RING-1:0][NB-1:0][c2ce_pkg::PIX_W-1:0] rd_data;

    logic                              mac_valid;
    logic                              mac_last;
    logic signed [c2ce_pkg::RES_W-1:0] mac_value;

    logic signed [c2ce_pkg::RES_W-1:0] fifo_data_reg [FQ];
    logic                              fifo_last_reg [FQ];
    logic [FPW-1:0]                    wr_ptr_reg;
    logic [FPW-1:0]                    rd_ptr_reg;
    logic [FPW:0]                      fifo_cnt_reg, fifo_cnt_next;
    logic [FPW:0]                      pend_reg,     pend_next;
    logic                              res_pop;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(image_width_reg);
        end
        h_eff = (image_height_reg == '0) ? HW'(1) : image_height_reg;
        rx_e  = (32'(radius_x_reg) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_x_reg);
        ry_e  = (32'(radius_y_reg) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_y_reg);
        wm1   = CW'(w_eff - WW'(1));
        rx_lag = (32'(rx_e) < 32'(w_eff)) ? CW'(rx_e) : wm1;
    end

    assign item_stall = (pend_reg == (FPW + 1)'(FQ));
    assign item_acc   = item_valid && !item_stall;

    always_comb
    begin
        pix_take = item_acc && (cmd == c2ce_pkg::CMD_PIXEL) && (in_row_reg < h_eff);
        col_last = (in_col_reg == wm1);
        pc       = in_col_reg;
        pr       = in_row_reg;
        pring    = in_ring_reg;
        if (pix_take)
        begin
            if (col_last)
            begin
                pc    = '0;
                pr    = in_row_reg + HW'(1);
                pring = (in_ring_reg == RGW'(RING - 1)) ? '0 : in_ring_reg + RGW'(1);
            end
            else
            begin
                pc = in_col_reg + CW'(1);
            end
        end

        s_sum  = {1'b0, xo_reg} + (CW + 1)'(rx_lag);
        s_wrap = (32'(s_sum) >= 32'(w_eff));
        tr     = YW'(yo_reg) + YW'(ry_e) + (s_wrap ? YW'(1) : YW'(0));
        tc     = s_wrap ? (s_sum - (CW + 1)'(w_eff)) : s_sum;
        ready  = (yo_reg < h_eff)
                 && ((pr >= h_eff) || (tr < YW'(pr)) || ((tr == YW'(pr)) && (tc < (CW + 1)'(pc))));
        release_o = item_acc && ((cmd == c2ce_pkg::CMD_PIXEL) || (cmd == c2ce_pkg::CMD_DRAIN))
                    && ready;
        last_o    = (xo_reg == wm1) && (yo_reg == h_eff - HW'(1));
    end

    always_comb
    begin
        in_col_next   = pc;
        in_row_next   = pr;
        in_ring_next  = pring;
        xo_next       = xo_reg;
        yo_next       = yo_reg;
        out_ring_next = out_ring_reg;
        if (release_o)
        begin
            if (last_o)
            begin
                in_col_next   = '0;
                in_row_next   = '0;
                in_ring_next  = '0;
                xo_next       = '0;
                yo_next       = '0;
                out_ring_next = '0;
            end
            else if (xo_reg == wm1)
            begin
                xo_next       = '0;
                yo_next       = yo_reg + HW'(1);
                out_ring_next = (out_ring_reg == RGW'(RING - 1)) ? '0 : out_ring_reg + RGW'(1);
            end
            else
            begin
                xo_next = xo_reg + CW'(1);
            end
        end
        if (cfg_we)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_ring_next  = '0;
            xo_next       = '0;
            yo_next       = '0;
            out_ring_next = '0;
        end
    end

    always_comb
    begin : p_taps
        logic signed [YW-1:0]  yo_s;
        logic signed [YW-1:0]  h_s;
        logic signed [YW-1:0]  ty_s;
        logic signed [YW-1:0]  rs;
        logic signed [XS-1:0]  xo_s;
        logic signed [XS-1:0]  wm1_s;
        logic signed [XS-1:0]  tx_s;
        logic [CW-1:0]         lo;
        logic [CXW-1:0]        lo_x;
        logic [LNB-1:0]        off;
        logic [CXW-1:0]        cb;
        yo_s  = $signed({2'b00, yo_reg});
        h_s   = $signed({2'b00, h_eff});
        xo_s  = $signed(XS'(xo_reg));
        wm1_s = $signed(XS'(wm1));
        for (int k = 0; k < KSIDE; k++)
        begin
            ty_s = yo_s + $signed(YW'(k)) - $signed(YW'(ry_e));
            if (ty_s < 0)
            begin
                ty_s = '0;
            end
            else if (ty_s >= h_s)
            begin
                ty_s = h_s - $signed(YW'(1));
            end
            rs = $signed(YW'(out_ring_reg)) + (ty_s - yo_s);
            if (rs < 0)
            begin
                rs = rs + $signed(YW'(RING));
            end
            else if (rs >= $signed(YW'(RING)))
            begin
                rs = rs - $signed(YW'(RING));
            end
            rr_c[k] = rs[RGW-1:0];

            tx_s = xo_s + $signed(XS'(k)) - $signed(XS'(rx_e));
            if (tx_s < 0)
            begin
                tx_s = '0;
            end
            else if (tx_s > wm1_s)
            begin
                tx_s = wm1_s;
            end
            bk_c[k] = tx_s[LNB-1:0];
        end
        lo   = (32'(xo_reg) >= 32'(rx_e)) ? (xo_reg - CW'(rx_e)) : '0;
        lo_x = CXW'(lo);
        for (int b = 0; b < NB; b++)
        begin
            off        = LNB'(b) - lo_x[LNB-1:0];
            cb         = lo_x + CXW'(off);
            raddr_c[b] = AW'(cb >> LNB);
        end
    end

    assign wcol_x = CXW'(in_col_reg);

    c2ce_linebuf #(
        .RING (RING),
        .NB   (NB),
        .AW   (AW)
    ) u_linebuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (pix_take),
        .wr_ring  (in_ring_reg),
        .wr_bank  (wcol_x[LNB-1:0]),
        .wr_addr  (AW'(wcol_x >> LNB)),
        .wr_pixel (pixel),
        .rd_addr  (raddr_c),
        .rd_data  (rd_data)
    );

    c2ce_mac #(
        .MAX_RADIUS (MAX_RADIUS),
        .RING       (RING),
        .NB         (NB)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld_en     (item_acc && (cmd == c2ce_pkg::CMD_LOAD)),
        .ld_index  (coef_index),
        .ld_value  (coef_value),
        .in_valid  (s1_valid_reg),
        .in_last   (s1_last_reg),
        .in_rr     (s1_rr_reg),
        .in_bk     (s1_bk_reg),
        .in_rx     (s1_rx_reg),
        .in_ry     (s1_ry_reg),
        .rd_data   (rd_data),
        .res_valid (mac_valid),
        .res_last  (mac_last),
        .res_value (mac_value)
    );

    assign res_valid  = (fifo_cnt_reg != '0);
    assign res_pop    = res_valid && !res_stall;
    assign result     = fifo_data_reg[rd_ptr_reg];
    assign frame_last = fifo_last_reg[rd_ptr_reg];

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg + (mac_valid ? (FPW + 1)'(1) : '0)
                        - (res_pop ? (FPW + 1)'(1) : '0);
        pend_next     = pend_reg + (release_o ? (FPW + 1)'(1) : '0)
                        - (res_pop ? (FPW + 1)'(1) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= c2ce_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= c2ce_pkg::RST_IMAGE_HEIGHT;
            radius_x_reg     <= c2ce_pkg::RST_RADIUS;
            radius_y_reg     <= c2ce_pkg::RST_RADIUS;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            in_ring_reg      <= '0;
            xo_reg           <= '0;
            yo_reg           <= '0;
            out_ring_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            fifo_cnt_reg     <= '0;
            pend_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    c2ce_pkg::REG_IMAGE_WIDTH:
                    begin
                        image_width_reg <= cfg_data[c2ce_pkg::IMGW_W-1:0];
                    end
                    c2ce_pkg::REG_IMAGE_HEIGHT:
                    begin
                        image_height_reg <= cfg_data[c2ce_pkg::IMGH_W-1:0];
                    end
                    c2ce_pkg::REG_RADIUS_X:
                    begin
                        radius_x_reg <= cfg_data[c2ce_pkg::RAD_W-1:0];
                    end
                    c2ce_pkg::REG_RADIUS_Y:
                    begin
                        radius_y_reg <= cfg_data[c2ce_pkg::RAD_W-1:0];
                    end
                    default:
                    begin
                        radius_y_reg <= radius_y_reg;
                    end
                endcase
            end
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_ring_reg  <= in_ring_next;
            xo_reg       <= xo_next;
            yo_reg       <= yo_next;
            out_ring_reg <= out_ring_next;
            s1_valid_reg <= release_o;
            if (mac_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FPW'(1);
            end
            if (res_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FPW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= last_o;
        s1_rr_reg   <= rr_c;
        s1_bk_reg   <= bk_c;
        s1_rx_reg   <= rx_e;
        s1_ry_reg   <= ry_e;
        if (mac_valid)
        begin
            fifo_data_reg[wr_ptr_reg] <= mac_value;
            fifo_last_reg[wr_ptr_reg] <= mac_last;
        end
    end

    a_queue_within_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= pend_reg)
        else $error("Queued results exceed released requests.");

    a_release_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        release_o |-> (yo_reg < h_eff) && (32'(xo_reg) < 32'(w_eff)))
        else $error("Output released outside the frame.");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (release_o && last_o) |=> (yo_reg == '0) && (xo_reg == '0) && (in_row_reg == '0)
                                  && (in_col_reg == '0))
        else $error("Positions not cleared after the last output of a frame.");

    a_pipe_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (pend_reg != '0))
        else $error("Request in flight without a pending credit.");

endmodule

// ----- bench/tb_conv2d_clamp_edge_top.sv -----
// ============================================================================
// tb_conv2d_clamp_edge_top
// Self-checking bench for the clamp-to-edge 2D convolution block.
//
// A behavioural predictor keeps its own kernel, line store and frame position.
// Each request that the block accepts goes through the predictor, and every
// output pixel is checked against the oldest expected value. Directed tests
// cover the kernel load, the border and geometry corner cases and the drain
// rules. Random frames follow, with bursty requests and a stalling receiver.
// ============================================================================
module tb_conv2d_clamp_edge_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KSIDE     = 2 * c2ce_pkg::MAX_RADIUS + 1;
    localparam int KTAPS     = KSIDE * KSIDE;
    localparam int RING_ROWS = 2 * c2ce_pkg::MAX_RADIUS + 2;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int WIDE_PIXELS = 40;
    localparam logic [c2ce_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic signed [c2ce_pkg::RES_W-1:0] result;
        logic                              frame_last;
    } out_pixel_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                item_valid = 1'b0;
    logic                                item_stall;
    logic [c2ce_pkg::CMD_W-1:0]          cmd = c2ce_pkg::CMD_LOAD;
    logic [c2ce_pkg::CIDX_W-1:0]         coef_index = '0;
    logic signed [c2ce_pkg::COEF_W-1:0]  coef_value = '0;
    logic [c2ce_pkg::PIX_W-1:0]          pixel = '0;
    logic                                res_valid;
    logic                                res_stall = 1'b0;
    logic signed [c2ce_pkg::RES_W-1:0]   result;
    logic                                frame_last;
    logic                                cfg_we = 1'b0;
    logic [c2ce_pkg::CFGI_W-1:0]         cfg_index = c2ce_pkg::REG_IMAGE_WIDTH;
    logic [c2ce_pkg::CFGD_W-1:0]         cfg_data = '0;

    // Predictor state.
    int unsigned                 kernel_mem [KTAPS];
    logic [c2ce_pkg::PIX_W-1:0]  line_mem [RING_ROWS*c2ce_pkg::MAX_WIDTH];
    int unsigned                 pos_col, pos_row, next_out;
    int unsigned                 img_w_reg, img_h_reg, rad_x_reg, rad_y_reg;

    out_pixel_t  pending_pixels [$];
    int          errors = 0;
    int          requests_sent = 0;
    int          pixels_checked = 0;
    int          frames_done = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    bit          valid_up = 1'b0;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          hold_cnt = 0;
    int          stall_phase = 0;
    int          idle_cycles = 0;

    conv2d_clamp_edge_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .pixel      (pixel),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .result     (result),
        .frame_last (frame_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned eff_w();
        if (img_w_reg == 0) return 1;
        if (img_w_reg > c2ce_pkg::MAX_WIDTH) return c2ce_pkg::MAX_WIDTH;
        return img_w_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (img_h_reg == 0) ? 1 : img_h_reg;
    endfunction

    function automatic int unsigned eff_rad(input int unsigned r);
        return (r > c2ce_pkg::MAX_RADIUS) ? c2ce_pkg::MAX_RADIUS : r;
    endfunction

    function automatic int unsigned clamp_tap(input int v, input int unsigned size);
        if (v < 0) return 0;
        if (v >= int'(size)) return size - 1;
        return v;
    endfunction

    function automatic int unsigned frame_lag();
        int unsigned w;
        int unsigned rx;
        w = eff_w();
        rx = eff_rad(rad_x_reg);
        return eff_rad(rad_y_reg) * w + ((rx < w) ? rx : w - 1);
    endfunction

    function automatic logic signed [c2ce_pkg::RES_W-1:0] convolve_pixel(input int unsigned o);
        int unsigned w, h, rx, ry, yo, xo, ty, tx, ci;
        longint acc;
        w = eff_w();
        h = eff_h();
        rx = eff_rad(rad_x_reg);
        ry = eff_rad(rad_y_reg);
        yo = o / w;
        xo = o % w;
        acc = 0;
        for (int yk = 0; yk < 2 * ry + 1; yk++)
        begin
            ty = clamp_tap(int'(yo) + yk - int'(ry), h);
            for (int xk = 0; xk < 2 * rx + 1; xk++)
            begin
                tx = clamp_tap(int'(xo) + xk - int'(rx), w);
                ci = yk * (2 * rx + 1) + xk;
                acc += longint'(int'(kernel_mem[ci])) *
                       longint'(line_mem[(ty % RING_ROWS) * c2ce_pkg::MAX_WIDTH + tx]);
            end
        end
        return acc[c2ce_pkg::RES_W-1:0];
    endfunction

    task automatic predict_request(input logic [c2ce_pkg::CMD_W-1:0] c,
                                   input logic [c2ce_pkg::CIDX_W-1:0] ci,
                                   input logic signed [c2ce_pkg::COEF_W-1:0] cv,
                                   input logic [c2ce_pkg::PIX_W-1:0] px);
        int unsigned w, h, col, received;
        out_pixel_t op;
        w = eff_w();
        h = eff_h();
        if (c == c2ce_pkg::CMD_LOAD)
        begin
            if (ci < KTAPS)
                kernel_mem[ci] = int'(cv);
            return;
        end
        if (c != c2ce_pkg::CMD_PIXEL && c != c2ce_pkg::CMD_DRAIN)
            return;
        if (c == c2ce_pkg::CMD_PIXEL && pos_row < h)
        begin
            col = (pos_col < w) ? pos_col : w - 1;
            line_mem[(pos_row % RING_ROWS) * c2ce_pkg::MAX_WIDTH + col] = px;
            pos_col = col + 1;
            if (pos_col >= w)
            begin
                pos_col = 0;
                pos_row++;
            end
        end
        received = pos_row * w + pos_col;
        if (next_out >= w * h)
            return;
        if (!(pos_row >= h || longint'(next_out) + frame_lag() < longint'(received)))
            return;
        op.result = convolve_pixel(next_out);
        next_out++;
        op.frame_last = (next_out >= w * h);
        if (op.frame_last)
        begin
            pos_col = 0;
            pos_row = 0;
            next_out = 0;
            frames_done++;
        end
        pending_pixels.push_back(op);
    endtask

    task automatic send_request(input logic [c2ce_pkg::CMD_W-1:0] c,
                                input logic [c2ce_pkg::CIDX_W-1:0] ci,
                                input logic signed [c2ce_pkg::COEF_W-1:0] cv,
                                input logic [c2ce_pkg::PIX_W-1:0] px);
        item_valid <= 1'b1;
        valid_up = 1'b1;
        cmd <= c;
        coef_index <= ci;
        coef_value <= cv;
        pixel <= px;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_request(c, ci, cv, px);
        requests_sent++;
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                item_valid <= 1'b0;
                valid_up = 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_random(input logic [c2ce_pkg::CMD_W-1:0] c);
        send_request(c, c2ce_pkg::CIDX_W'($urandom), c2ce_pkg::COEF_W'($urandom),
                     c2ce_pkg::PIX_W'($urandom));
    endtask

    task automatic drop_valid();
        if (valid_up)
        begin
            item_valid <= 1'b0;
            valid_up = 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_results();
        drop_valid();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [c2ce_pkg::CFGI_W-1:0] idx, input int unsigned value);
        wait_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[c2ce_pkg::CFGD_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            c2ce_pkg::REG_IMAGE_WIDTH:  img_w_reg = value & 16'h07FF;
            c2ce_pkg::REG_IMAGE_HEIGHT: img_h_reg = value & 16'hFFFF;
            c2ce_pkg::REG_RADIUS_X:     rad_x_reg = value & 16'h0007;
            default:                    rad_y_reg = value & 16'h0007;
        endcase
        pos_col = 0;
        pos_row = 0;
        next_out = 0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned rx, input int unsigned ry);
        write_reg(c2ce_pkg::REG_IMAGE_WIDTH, w);
        write_reg(c2ce_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(c2ce_pkg::REG_RADIUS_X, rx);
        write_reg(c2ce_pkg::REG_RADIUS_Y, ry);
    endtask

    task automatic run_frame(input int unsigned noise_pct);
        int unsigned n;
        n = eff_w() * eff_h();
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(1, 100) <= noise_pct)
            begin
                case ($urandom_range(0, 2))
                    0: send_random(c2ce_pkg::CMD_LOAD);
                    1: send_random(c2ce_pkg::CMD_DRAIN);
                    default: send_random(CMD_UNKNOWN);
                endcase
            end
            send_random(c2ce_pkg::CMD_PIXEL);
        end
        repeat (frame_lag() + 3)
            send_random($urandom_range(0, 1) ? c2ce_pkg::CMD_DRAIN : c2ce_pkg::CMD_PIXEL);
    endtask

    task automatic test_kernel_load();
        for (int i = 0; i < KTAPS; i++)
            send_random_load(c2ce_pkg::CIDX_W'(i));
        send_request(c2ce_pkg::CMD_LOAD, c2ce_pkg::CIDX_W'(0), 16'sh7FFF, 8'h00);
        send_request(c2ce_pkg::CMD_LOAD, c2ce_pkg::CIDX_W'(1), -16'sh8000, 8'hFF);
        send_request(c2ce_pkg::CMD_LOAD, c2ce_pkg::CIDX_W'(KTAPS), 16'sh1234, 8'h00);
        send_request(c2ce_pkg::CMD_LOAD, 7'h7F, -16'sh1, 8'hFF);
        send_request(CMD_UNKNOWN, 7'h7F, -16'sh1, 8'hFF);
    endtask

    task automatic send_random_load(input logic [c2ce_pkg::CIDX_W-1:0] ci);
        send_request(c2ce_pkg::CMD_LOAD, ci, c2ce_pkg::COEF_W'($urandom),
                     c2ce_pkg::PIX_W'($urandom));
    endtask

    task automatic test_small_frame();
        set_geometry(3, 2, 1, 1);
        send_request(c2ce_pkg::CMD_DRAIN, '0, '0, '0);
        send_request(c2ce_pkg::CMD_PIXEL, '0, '0, 8'hFF);
        send_request(c2ce_pkg::CMD_PIXEL, '0, '0, 8'h00);
        send_request(c2ce_pkg::CMD_PIXEL, '0, '0, 8'hFF);
        send_request(c2ce_pkg::CMD_PIXEL, '0, '0, 8'h00);
        send_request(c2ce_pkg::CMD_PIXEL, '0, '0, 8'hFF);
        send_request(c2ce_pkg::CMD_PIXEL, '0, '0, 8'h80);
        send_request(c2ce_pkg::CMD_PIXEL, '0, '0, 8'h01);
        send_request(c2ce_pkg::CMD_PIXEL, '0, '0, 8'h02);
        send_request(c2ce_pkg::CMD_DRAIN, '0, '0, '0);
        send_request(c2ce_pkg::CMD_DRAIN, '0, '0, '0);
        send_request(c2ce_pkg::CMD_DRAIN, '0, '0, '0);
    endtask

    task automatic test_geometry_limits();
        set_geometry(1, 3, 4, 4);
        run_frame(0);
        set_geometry(0, 0, 7, 7);
        run_frame(0);
        set_geometry(5, 4, 0, 0);
        run_frame(0);
        set_geometry(2, 4, 3, 6);
        run_frame(0);
        // The start of an over-wide row; the next register write restarts the frame.
        set_geometry(11'h7FF, 1, 4, 0);
        no_gaps = 1'b1;
        for (int i = 0; i < WIDE_PIXELS; i++)
            send_random(c2ce_pkg::CMD_PIXEL);
        repeat (3)
            send_random(c2ce_pkg::CMD_DRAIN);
        no_gaps = 1'b0;
    endtask

    task automatic test_back_pressure();
        set_geometry(10, 4, 2, 1);
        hold_asked++;
        run_frame(0);
        wait_results();
        run_frame(5);
    endtask

    task automatic test_random_frames();
        while (requests_sent < 620)
        begin
            write_reg(c2ce_pkg::REG_RADIUS_X, ($urandom_range(0, 7) == 0) ?
                      $urandom_range(5, 7) : $urandom_range(0, 4));
            write_reg(c2ce_pkg::REG_RADIUS_Y, ($urandom_range(0, 7) == 0) ?
                      $urandom_range(5, 7) : $urandom_range(0, 4));
            write_reg(c2ce_pkg::REG_IMAGE_WIDTH, ($urandom_range(0, 7) == 0) ?
                      $urandom_range(13, 40) : $urandom_range(1, 12));
            write_reg(c2ce_pkg::REG_IMAGE_HEIGHT, $urandom_range(1, 5));
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 4))
                send_random_load(c2ce_pkg::CIDX_W'($urandom_range(0, KTAPS - 1)));
            run_frame(10);
            if ($urandom_range(0, 3) == 0)
                wait_results();
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_cnt <= 0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_cnt > 0)
            begin
                res_stall <= 1'b1;
                hold_cnt <= hold_cnt - 1;
            end
            else if (hold_served != hold_asked)
            begin
                hold_served <= hold_asked;
                hold_cnt <= 300;
                res_stall <= 1'b1;
            end
            else
            begin
                case ((stall_phase / 64) % 3)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 3) == 0);
                    default: res_stall <= ($urandom_range(0, 9) < 6);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected output pixel: expected none, actual %0d/%0b",
                         $realtime, result, frame_last);
                errors++;
            end
            else
            begin
                if (result !== pending_pixels[0].result)
                begin
                    $display("%0t: result mismatch: expected %0d, actual %0d",
                             $realtime, pending_pixels[0].result, result);
                    errors++;
                end
                if (frame_last !== pending_pixels[0].frame_last)
                begin
                    $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                             $realtime, pending_pixels[0].frame_last, frame_last);
                    errors++;
                end
                void'(pending_pixels.pop_front());
                pixels_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < KTAPS; i++)
            kernel_mem[i] = 0;
        pos_col = 0;
        pos_row = 0;
        next_out = 0;
        img_w_reg = c2ce_pkg::RST_IMAGE_WIDTH;
        img_h_reg = c2ce_pkg::RST_IMAGE_HEIGHT;
        rad_x_reg = c2ce_pkg::RST_RADIUS;
        rad_y_reg = c2ce_pkg::RST_RADIUS;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_kernel_load();
        test_small_frame();
        test_geometry_limits();
        test_back_pressure();
        test_random_frames();

        wait_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d requests over %0d frames and checked %0d output pixels,",
                 requests_sent, frames_done, pixels_checked);
        $display("covering border clamping, geometry limits, drains and back-pressure.");
        if (errors == 0 && pending_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
src/c2ce_pkg.sv
src/c2ce_linebuf.sv
src/c2ce_mac.sv
src/conv2d_clamp_edge_top.sv
bench/tb_conv2d_clamp_edge_top.sv
